>>> hw/rtl/rad_pkg.sv
// Shared types and constants for the signal-strength deviation trigger.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rad_pkg;

  localparam int NODES_DEF = 16;

  // Operation codes carried in the op field
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS   = 1'd1;
  localparam int CFG_DATA_W = 16;

  localparam logic [11:0] TRIGGER_RATIO_RST = 12'd384;
  localparam logic [15:0] COOLDOWN_MS_RST   = 16'd1000;

  localparam logic [11:0] RATIO_ONE = 12'd256;
  localparam logic [11:0] RATIO_MAX = 12'd4095;
  localparam logic [24:0] RATIO_PROD_ONE = 25'd65536;
  localparam logic [15:0] SINCE_MAX = 16'hFFFF;

  // Blend: u = 9*avg + rssi*256 + 5 + 10*32768 stays in [0, 2^20);
  // floor(u/10) = (u * ceil(2^23/10)) >> 23 is exact over that range.
  localparam logic signed [21:0] BLEND_BIAS = 22'sd327685;
  localparam logic [19:0] RECIP_10 = 20'd838861;
  localparam int RECIP_SHIFT = 23;

  typedef struct packed {
    logic [11:0] ratio;
    logic [15:0] avg;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/rad_mem.sv
// Per-node store: one synchronous memory of {ratio, average} entries and
// a seen bit per node. Depends on rad_pkg.
`timescale 1ns / 1ps

module rad_mem #(
  parameter int NODES = rad_pkg::NODES_DEF,
  parameter int IDX_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rad_pkg::mem_req_t req_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  rad_pkg::entry_t   wr_data_i,
  output rad_pkg::entry_t   rd_data_o,
  output logic              rd_seen_o
);
  import rad_pkg::*;

  entry_t           mem_q [NODES];
  entry_t           rd_data_q;
  logic [NODES-1:0] seen_q;
  logic             rd_seen_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      rd_seen_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        seen_q[wr_addr_i] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_seen_q <= seen_q[rd_addr_i];
      end
    end
  end

  // An unseen node reads with ratio 1.0; its average is not meaningful.
  always_comb begin
    rd_data_o.avg   = rd_data_q.avg;
    rd_data_o.ratio = rd_seen_q ? rd_data_q.ratio : RATIO_ONE;
  end
  assign rd_seen_o = rd_seen_q;

endmodule

>>> hw/rtl/rad_div.sv
// Restoring divider for the Q4.8 ratio: one quotient bit per cycle,
// clamped to 4095 on overflow. Depends on rad_pkg.
`timescale 1ns / 1ps

module rad_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [23:0]        num_i,
  input  logic [15:0]        den_i,
  output rad_pkg::div_stat_t stat_o,
  output logic [11:0]        quo_o
);
  import rad_pkg::*;

  logic [23:0] rem_q;
  logic [26:0] dsh_q;
  logic [11:0] quo_q;
  logic [3:0]  step_q;
  logic        busy_q;
  logic        done_q;
  logic        fits;

  assign fits = {3'b000, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      if ({4'b0000, num_i} >= {den_i, 12'b0}) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        step_q <= 4'd11;
      end
    end else if (busy_q) begin
      step_q <= step_q - 4'd1;
      if (step_q == 4'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, 11'b0};
      quo_q <= ({4'b0000, num_i} >= {den_i, 12'b0}) ? RATIO_MAX : '0;
    end else if (busy_q) begin
      // subtract the shifted divisor when it fits, shift in the quotient bit
      if (fits) begin
        rem_q <= rem_q - dsh_q[23:0];
      end
      quo_q <= {quo_q[10:0], fits};
      dsh_q <= {1'b0, dsh_q[26:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

>>> hw/rtl/rssi_average_deviation_trigger_top.sv
// Signal-strength deviation trigger, top level. Uses rad_pkg, rad_mem, rad_div.
// Record: read, blend, multiply, 12-step serial divider, write back, result; no divide
// when the average is zero or the signs differ. Query: one memory read per node; a query
// inside the cooldown, or a record with an index out of range, goes straight to the
// result. Tick: no result. One word in work at a time; output stalls hold the result.
// Reset: async active low; seen bits and counters clear, registers take defaults.
`timescale 1ns / 1ps

module rssi_average_deviation_trigger_top #(
  parameter int NODES = rad_pkg::NODES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rad_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rad_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      op_i,
  input  logic [7:0]                      node_index_i,
  input  logic signed [7:0]               rssi_dbm_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            status_o,
  output logic [11:0]                     relative_ratio_o,
  output logic signed [15:0]              new_average_o,
  output logic                            fired_o
);
  import rad_pkg::*;

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_CALC, ST_MUL, ST_DIV, ST_WB, ST_SCAN, ST_DONE
  } state_e;

  state_e            state_q;
  logic [11:0]       trig_q;
  logic [15:0]       cool_q;
  logic [15:0]       since_q;
  logic [IDX_W-1:0]  idx_q;
  logic signed [7:0] rssi_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              ev_vld_q;
  logic              fire_q;
  logic              special_q;
  logic [11:0]       ratio_q;
  logic [19:0]       u_q;
  logic [39:0]       prod_q;
  logic              res_status_q;
  logic [11:0]       res_ratio_q;
  logic [15:0]       res_avg_q;
  logic              res_fired_q;
  logic              out_valid_q;
  logic              out_status_q;
  logic [11:0]       out_ratio_q;
  logic [15:0]       out_avg_q;
  logic              out_fired_q;

  mem_req_t          mem_req;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  logic              rd_seen;
  div_stat_t         div_stat;
  logic [11:0]       div_quo;
  logic              div_start;

  logic signed [15:0] avg_cur;
  logic [7:0]         rssi_mag;
  logic [15:0]        avg_mag;
  logic signed [21:0] blend_sum;
  logic               avg_zero;
  logic               sign_diff;
  logic [15:0]        new_avg;
  logic               hit;
  logic               scan_last;
  logic               out_free;
  logic               res_push;

  // seed on first use, then split into magnitudes and signs for the divider
  always_comb begin
    avg_cur   = rd_seen ? $signed(rd_data.avg) : $signed({rssi_q, 8'h00});
    rssi_mag  = rssi_q[7] ? 8'(-rssi_q) : 8'(rssi_q);
    avg_mag   = avg_cur[15] ? 16'(-avg_cur) : 16'(avg_cur);
    avg_zero  = (avg_cur == 16'sd0);
    sign_diff = rssi_q[7] ^ avg_cur[15];
    blend_sum = (22'(avg_cur) <<< 3) + 22'(avg_cur)
              + (22'(rssi_q) <<< 8) + BLEND_BIAS;
  end

  // floor(u/10) is offset by 32768; flipping the top bit removes the offset
  assign new_avg = prod_q[RECIP_SHIFT+15:RECIP_SHIFT] ^ 16'h8000;

  assign hit = (rd_data.ratio >= trig_q)
            || ((25'(rd_data.ratio) * 25'(trig_q)) <= RATIO_PROD_ONE);
  assign scan_last = (cnt_q == CNT_W'(NODES));
  assign div_start = (state_q == ST_CALC) && !avg_zero && !sign_diff;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign res_push  = (state_q == ST_DONE) && out_free;

  always_comb begin
    mem_req.rd_en = (state_q == ST_RD) || ((state_q == ST_SCAN) && !scan_last);
    mem_req.wr_en = (state_q == ST_WB);
    rd_addr       = (state_q == ST_SCAN) ? cnt_q[IDX_W-1:0] : idx_q;
    wr_data.ratio = ratio_q;
    wr_data.avg   = new_avg;
  end

  rad_mem #(
    .NODES(NODES),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_addr_i(rd_addr),
    .wr_addr_i(idx_q),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data),
    .rd_seen_o(rd_seen)
  );

  rad_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({rssi_mag, 16'h0000}),
    .den_i  (avg_mag),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      trig_q      <= TRIGGER_RATIO_RST;
      cool_q      <= COOLDOWN_MS_RST;
      since_q     <= '0;
      out_valid_q <= 1'b0;
      ev_vld_q    <= 1'b0;
      fire_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_TRIGGER_RATIO: trig_q <= cfg_data_i[11:0];
          REG_COOLDOWN_MS:   cool_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (res_push) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          res_status_q <= (op_i == OP_RECORD) && ({1'b0, node_index_i} >= 9'(NODES));
          res_ratio_q  <= '0;
          res_avg_q    <= '0;
          res_fired_q  <= 1'b0;
          idx_q        <= node_index_i[IDX_W-1:0];
          rssi_q       <= rssi_dbm_i;
          cnt_q        <= '0;
          ev_vld_q     <= 1'b0;
          fire_q       <= 1'b0;
          if (in_valid_i) begin
            unique case (op_i)
              OP_RECORD: begin
                if ({1'b0, node_index_i} < 9'(NODES)) begin
                  state_q <= ST_RD;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              OP_QUERY: begin
                state_q <= (since_q < cool_q) ? ST_DONE : ST_SCAN;
              end
              OP_TICK: begin
                if (since_q != SINCE_MAX) begin
                  since_q <= since_q + 16'd1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RD: begin
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          u_q       <= blend_sum[19:0];
          special_q <= avg_zero || sign_diff;
          ratio_q   <= avg_zero ? RATIO_MAX : '0;
          state_q   <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= u_q * RECIP_10;
          state_q <= special_q ? ST_WB : ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done && !div_stat.busy) begin
            ratio_q <= div_quo;
            state_q <= ST_WB;
          end
        end
        ST_WB: begin
          res_ratio_q <= ratio_q;
          res_avg_q   <= new_avg;
          state_q     <= ST_DONE;
        end
        ST_SCAN: begin
          // read node cnt while judging the node read in the previous cycle
          ev_vld_q <= !scan_last;
          if (!scan_last) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (ev_vld_q && hit) begin
            fire_q <= 1'b1;
          end
          if (scan_last) begin
            res_fired_q <= fire_q || (ev_vld_q && hit);
            if (fire_q || (ev_vld_q && hit)) begin
              since_q <= '0;
            end
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_status_q <= res_status_q;
            out_ratio_q  <= res_ratio_q;
            out_avg_q    <= res_avg_q;
            out_fired_q  <= res_fired_q;
            state_q      <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign relative_ratio_o = out_ratio_q;
  assign new_average_o    = $signed(out_avg_q);
  assign fired_o          = out_fired_q;

endmodule
